// ===== sv/svp_pkg.sv =====
// Shared types and constants of the streaming vertex partitioner.
// Holds the command/status structs between controller and datapath.
// No dependencies.
package svp_pkg;

    localparam int SVP_MAX_VERTICES = 4096;
    localparam int SVP_MAX_DCS      = 16;

    localparam int SVP_VID_W  = 12;
    localparam int SVP_DEG_W  = 16;
    localparam int SVP_DC_W   = 4;
    localparam int SVP_CNT_W  = 16;
    localparam int SVP_WGT_W  = 24;
    localparam int SVP_BAL_W  = 40;
    localparam int SVP_ROOT_W = 28;
    localparam int SVP_PEN_W  = 36;
    localparam int SVP_SCORE_W = 38;
    localparam int SVP_NDC_W  = 5;

    localparam logic [SVP_CNT_W-1:0] SVP_CNT_MAX = '1;
    localparam logic [SVP_BAL_W-1:0] SVP_BAL_MAX = '1;
    // one vertex in Q24.16
    localparam logic [SVP_BAL_W:0]   SVP_BAL_ONE = 41'd65536;

    typedef enum logic [1:0] {
        CMD_DEGREE = 2'd0,
        CMD_EDGE   = 2'd1,
        CMD_END    = 2'd2,
        CMD_NONE   = 2'd3
    } svp_command_t;

    typedef enum logic [1:0] {
        REG_NUM_DCS   = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_WEIGHT    = 2'd2,
        REG_RATIO     = 2'd3
    } svp_reg_t;

    typedef struct packed {
        logic latch;
        logic deg_wr;
        logic rd_cur;
        logic edge_eval;
        logic loc_inc;
        logic scan_init;
        logic scan_cap;
        logic mul_cap;
        logic score_cap;
        logic upd_mul;
        logic place;
        logic clr_step;
        logic clr_bal;
    } svp_ctl_t;

    typedef struct packed {
        logic sqrt_done;
        logic loc_needed;
        logic scan_last;
        logic clr_last;
    } svp_stat_t;

endpackage

// ===== sv/svp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/svp_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
// Depends on svp_pkg.
module svp_sqrt
    import svp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2*SVP_ROOT_W-1:0] radicand,
    output logic                    done,
    output logic [SVP_ROOT_W-1:0]   root
);

    localparam int CW = $clog2(SVP_ROOT_W);

    logic                    run_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [2*SVP_ROOT_W-1:0] x_reg;
    logic [SVP_ROOT_W+1:0]   rem_reg;
    logic [SVP_ROOT_W-1:0]   root_reg;

    logic [SVP_ROOT_W+2:0]   rem_sh;
    logic [SVP_ROOT_W+2:0]   trial;
    logic                    take;
    logic [SVP_ROOT_W+1:0]   rem_next;
    logic [SVP_ROOT_W-1:0]   root_next;

    always_comb
    begin
        rem_sh = {rem_reg[SVP_ROOT_W:0], x_reg[2*SVP_ROOT_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = rem_sh >= trial;
        if (take)
        begin
            rem_next  = (SVP_ROOT_W+2)'(rem_sh - trial);
            root_next = {root_reg[SVP_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = (SVP_ROOT_W+2)'(rem_sh);
            root_next = {root_reg[SVP_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(SVP_ROOT_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            x_reg    <= {x_reg[2*SVP_ROOT_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sv/svp_ctrl.sv =====
// Controller state machine: sequences degree, edge and end-of-vertex requests
// and the locality/balance clearing sweeps. Depends on svp_pkg.
module svp_ctrl
    import svp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   command,
    input  svp_stat_t    stat,
    output svp_ctl_t     ctl,
    output logic         busy
);

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_DEG,
        S_E_CUR,
        S_E_NB,
        S_E_EVAL,
        S_E_INC,
        S_RD,
        S_CAP,
        S_SQ,
        S_MUL,
        S_CMP,
        S_UPD,
        S_PLACE,
        S_CLR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_RST_CLR:
            begin
                ctl.clr_step = 1'b1;
                ctl.clr_bal  = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch = 1'b1;
                    unique case (svp_command_t'(command))
                        CMD_DEGREE: state_next = S_DEG;
                        CMD_EDGE:
                        begin
                            state_next = S_E_CUR;
                        end
                        CMD_END:
                        begin
                            ctl.scan_init = 1'b1;
                            state_next    = S_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DEG:
            begin
                ctl.deg_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_E_CUR:
            begin
                ctl.rd_cur = 1'b1;
                state_next = S_E_NB;
            end
            S_E_NB:
            begin
                state_next = S_E_EVAL;
            end
            S_E_EVAL:
            begin
                ctl.edge_eval = 1'b1;
                state_next    = stat.loc_needed ? S_E_INC : S_IDLE;
            end
            S_E_INC:
            begin
                ctl.loc_inc = 1'b1;
                state_next  = S_IDLE;
            end
            S_RD:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                ctl.scan_cap = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul_cap = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                ctl.score_cap = 1'b1;
                state_next    = stat.scan_last ? S_UPD : S_RD;
            end
            S_UPD:
            begin
                ctl.upd_mul = 1'b1;
                state_next  = S_PLACE;
            end
            S_PLACE:
            begin
                ctl.place  = 1'b1;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

// ===== sv/svp_datapath.sv =====
// Datapath: configuration registers, vertex tables, per-DC locality and
// balance memories, scoring and balance update. Depends on svp_pkg,
// svp_ram and svp_sqrt.
module svp_datapath
    import svp_pkg::*;
#(
    parameter int MAX_VERTICES = SVP_MAX_VERTICES,
    parameter int MAX_DCS      = SVP_MAX_DCS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  svp_ctl_t             ctl,
    output svp_stat_t            stat,
    input  logic [SVP_VID_W-1:0] vertex_id,
    input  logic [SVP_DEG_W-1:0] in_degree,
    input  logic [SVP_VID_W-1:0] neighbor_id,
    input  logic                 edge_outgoing,
    input  logic                 write_enable,
    input  logic [1:0]           reg_index,
    input  logic [23:0]          write_data,
    output logic                 done,
    output logic [SVP_VID_W-1:0] placed_vertex,
    output logic [SVP_DC_W-1:0]  chosen_dc
);

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(MAX_DCS);
    localparam int JW = $clog2(MAX_DCS + 1);
    localparam int PW = SVP_WGT_W + SVP_ROOT_W;

    // configuration
    logic [SVP_NDC_W-1:0] num_dcs_reg;
    logic [SVP_DEG_W-1:0] threshold_reg;
    logic [SVP_WGT_W-1:0] weight_reg;
    logic [SVP_WGT_W-1:0] ratio_reg;

    // latched request
    logic [SVP_VID_W-1:0] vid_reg;
    logic [SVP_DEG_W-1:0] deg_reg;
    logic [SVP_VID_W-1:0] nb_reg;
    logic                 out_reg;

    logic [VA-1:0]        cur_reg;
    logic [VA-1:0]        cur_next;
    logic [SVP_CNT_W-1:0] follow_reg;
    logic                 cur_high_reg;
    logic [LW-1:0]        lab_reg;

    logic [JW-1:0]        j_reg;
    logic [LW-1:0]        best_reg;
    logic [SVP_BAL_W-1:0] best_bal_reg;
    logic signed [SVP_SCORE_W-1:0] best_score_reg;
    logic [SVP_BAL_W-1:0] bal_cap_reg;
    logic [SVP_CNT_W-1:0] loc_cap_reg;
    logic [SVP_PEN_W-1:0] pen_reg;
    logic [SVP_BAL_W-1:0] add_mul_reg;
    logic [LW-1:0]        clr_reg;

    logic                 done_reg;
    logic [SVP_VID_W-1:0] placed_reg;
    logic [SVP_DC_W-1:0]  chosen_reg;

    // memory ports
    logic                 high_we;
    logic [VA-1:0]        high_raddr;
    logic                 high_rdata;
    logic [LW-1:0]        lab_rdata;
    logic                 loc_we;
    logic [LW-1:0]        loc_waddr;
    logic [SVP_CNT_W-1:0] loc_wdata;
    logic [LW-1:0]        loc_raddr;
    logic [SVP_CNT_W-1:0] loc_rdata;
    logic                 bal_we;
    logic [LW-1:0]        bal_waddr;
    logic [SVP_BAL_W-1:0] bal_wdata;
    logic [SVP_BAL_W-1:0] bal_rdata;

    logic                 vid_ok;
    logic                 nb_ok;
    logic                 counted;
    logic [JW-1:0]        n_eff;
    logic                 root_done;
    logic [SVP_ROOT_W-1:0] root;
    logic [PW-1:0]        pen_full;
    logic signed [SVP_SCORE_W-1:0] score;
    logic [SVP_BAL_W+1:0] bal_sum;
    logic [SVP_BAL_W-1:0] bal_new;

    assign vid_ok = 32'(vid_reg) < MAX_VERTICES;
    assign nb_ok  = 32'(nb_reg) < MAX_VERTICES;

    // effective DC count, clamped to 1..MAX_DCS
    always_comb
    begin
        if (num_dcs_reg == '0)
        begin
            n_eff = JW'(1);
        end
        else if (32'(num_dcs_reg) > MAX_DCS)
        begin
            n_eff = JW'(MAX_DCS);
        end
        else
        begin
            n_eff = JW'(num_dcs_reg);
        end
    end

    // an incoming edge counts for a low-degree vertex, an outgoing one for a
    // high-degree neighbour
    assign counted = out_reg ? (nb_ok && high_rdata) : !cur_high_reg;

    assign stat.loc_needed = counted && nb_ok && (32'(nb_reg) < 32'(cur_reg))
                             && (32'(lab_rdata) < MAX_DCS);
    assign stat.scan_last  = (j_reg + JW'(1)) == n_eff;
    assign stat.clr_last   = 32'(clr_reg) == MAX_DCS - 1;
    assign stat.sqrt_done  = root_done;

    assign high_we    = ctl.deg_wr && vid_ok;
    assign high_raddr = ctl.rd_cur ? cur_reg : VA'(nb_reg);

    assign loc_raddr = ctl.edge_eval ? lab_rdata : j_reg[LW-1:0];
    assign loc_we    = ctl.loc_inc || ctl.clr_step;
    assign loc_waddr = ctl.clr_step ? clr_reg : lab_reg;
    always_comb
    begin
        if (ctl.clr_step)
        begin
            loc_wdata = '0;
        end
        else if (loc_rdata == SVP_CNT_MAX)
        begin
            loc_wdata = loc_rdata;
        end
        else
        begin
            loc_wdata = loc_rdata + 1'b1;
        end
    end

    assign bal_sum = {2'b00, best_bal_reg} + {2'b00, add_mul_reg} + {1'b0, SVP_BAL_ONE};
    assign bal_new = (bal_sum > {2'b00, SVP_BAL_MAX}) ? SVP_BAL_MAX
                                                      : bal_sum[SVP_BAL_W-1:0];
    assign bal_we    = ctl.place || (ctl.clr_step && ctl.clr_bal);
    assign bal_waddr = ctl.place ? best_reg : clr_reg;
    assign bal_wdata = ctl.place ? bal_new : '0;

    assign pen_full = PW'(weight_reg) * PW'(root);
    assign score = $signed({{(SVP_SCORE_W-SVP_CNT_W-16){1'b0}}, loc_cap_reg, 16'h0000})
                 - $signed({{(SVP_SCORE_W-SVP_PEN_W){1'b0}}, pen_reg});

    assign cur_next = (32'(cur_reg) == MAX_VERTICES - 1) ? '0 : cur_reg + 1'b1;

    svp_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_high (
        .clk   (clk),
        .we    (high_we),
        .waddr (VA'(vid_reg)),
        .wdata (deg_reg >= threshold_reg),
        .raddr (high_raddr),
        .rdata (high_rdata)
    );

    svp_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_label (
        .clk   (clk),
        .we    (ctl.place),
        .waddr (cur_reg),
        .wdata (best_reg),
        .raddr (VA'(nb_reg)),
        .rdata (lab_rdata)
    );

    svp_ram #(.WIDTH(SVP_CNT_W), .DEPTH(MAX_DCS)) u_loc (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (loc_raddr),
        .rdata (loc_rdata)
    );

    svp_ram #(.WIDTH(SVP_BAL_W), .DEPTH(MAX_DCS)) u_bal (
        .clk   (clk),
        .we    (bal_we),
        .waddr (bal_waddr),
        .wdata (bal_wdata),
        .raddr (j_reg[LW-1:0]),
        .rdata (bal_rdata)
    );

    svp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.scan_cap),
        .radicand ({bal_rdata, 16'h0000}),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dcs_reg   <= SVP_NDC_W'(1);
            threshold_reg <= SVP_DEG_W'(100);
            weight_reg    <= SVP_WGT_W'(65536);
            ratio_reg     <= SVP_WGT_W'(65536);
            cur_reg       <= '0;
            follow_reg    <= '0;
            j_reg         <= '0;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                unique case (svp_reg_t'(reg_index))
                    REG_NUM_DCS:   num_dcs_reg   <= write_data[SVP_NDC_W-1:0];
                    REG_THRESHOLD: threshold_reg <= write_data[SVP_DEG_W-1:0];
                    REG_WEIGHT:    weight_reg    <= write_data;
                    REG_RATIO:     ratio_reg     <= write_data;
                    default:       num_dcs_reg   <= num_dcs_reg;
                endcase
            end
            if (ctl.edge_eval && counted && follow_reg != SVP_CNT_MAX)
            begin
                follow_reg <= follow_reg + 1'b1;
            end
            if (ctl.scan_init)
            begin
                j_reg <= '0;
            end
            else if (ctl.score_cap)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (ctl.clr_step)
            begin
                clr_reg <= stat.clr_last ? '0 : clr_reg + 1'b1;
            end
            done_reg <= ctl.place;
            if (ctl.place)
            begin
                cur_reg    <= cur_next;
                follow_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            vid_reg <= vertex_id;
            deg_reg <= in_degree;
            nb_reg  <= neighbor_id;
            out_reg <= edge_outgoing;
        end
        if (ctl.rd_cur == 1'b0 && ctl.edge_eval == 1'b0)
        begin
            cur_high_reg <= high_rdata;
        end
        if (ctl.edge_eval)
        begin
            lab_reg <= lab_rdata;
        end
        if (ctl.scan_cap)
        begin
            bal_cap_reg <= bal_rdata;
            loc_cap_reg <= loc_rdata;
        end
        if (ctl.mul_cap)
        begin
            pen_reg <= pen_full[PW-1:16];
        end
        if (ctl.score_cap && (j_reg == '0 || score > best_score_reg))
        begin
            best_score_reg <= score;
            best_reg       <= j_reg[LW-1:0];
            best_bal_reg   <= bal_cap_reg;
        end
        if (ctl.upd_mul)
        begin
            add_mul_reg <= SVP_BAL_W'(follow_reg) * SVP_BAL_W'(ratio_reg);
        end
        if (ctl.place)
        begin
            placed_reg <= SVP_VID_W'(cur_reg);
            chosen_reg <= SVP_DC_W'(best_reg);
        end
    end

    assign done          = done_reg;
    assign placed_vertex = placed_reg;
    assign chosen_dc     = chosen_reg;

endmodule

// ===== sv/streaming_vertex_partitioner_core.sv =====
// Top level of the streaming vertex partitioner.
// Depends on svp_pkg, svp_ctrl and svp_datapath.
//
// Usage:
//   Requests enter on start/command with their fields; a request is taken
//   at a clock edge where start is high and busy is low. Command 0 records a
//   vertex in-degree, command 1 is an edge of the current vertex, command 2
//   places the current vertex (each of the n DCs, n the DC count after
//   clamping, takes a read, a 28-step pass of the shared root unit, a
//   multiply and a compare, then the per-DC locality memory is cleared one
//   entry a cycle). Command 3 is dropped.
//   A placement shows placed_vertex and chosen_dc with done high for exactly
//   one cycle; the receiver cannot stall the block.
//   Configuration writes use write_enable/reg_index/write_data and take
//   effect at once; write them only while busy is low.
//   After reset the block clears its locality and balance memories with
//   busy high, then waits for requests.
module streaming_vertex_partitioner_core
    import svp_pkg::*;
#(
    parameter int MAX_VERTICES = SVP_MAX_VERTICES,
    parameter int MAX_DCS      = SVP_MAX_DCS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [SVP_VID_W-1:0] vertex_id,
    input  logic [SVP_DEG_W-1:0] in_degree,
    input  logic [SVP_VID_W-1:0] neighbor_id,
    input  logic                 edge_outgoing,
    input  logic                 write_enable,
    input  logic [1:0]           reg_index,
    input  logic [23:0]          write_data,
    output logic                 done,
    output logic [SVP_VID_W-1:0] placed_vertex,
    output logic [SVP_DC_W-1:0]  chosen_dc
);

    svp_ctl_t  ctl;
    svp_stat_t stat;

    svp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy)
    );

    svp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DCS      (MAX_DCS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .vertex_id     (vertex_id),
        .in_degree     (in_degree),
        .neighbor_id   (neighbor_id),
        .edge_outgoing (edge_outgoing),
        .write_enable  (write_enable),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .done          (done),
        .placed_vertex (placed_vertex),
        .chosen_dc     (chosen_dc)
    );

endmodule
